### hw/rtl/nlfr_pkg.sv
// Package for the nibble link framed receiver.
// Line codes, phase codes and stream widths; no dependencies.
package nlfr_pkg;

    localparam int CodeW   = 4;
    localparam int PacketW = 3;
    localparam int PhaseW  = 2;
    localparam int HeldW   = 2;

    localparam logic [CodeW-1:0] CODE_START = 4'd8;
    localparam logic [CodeW-1:0] CODE_DEN   = 4'd9;
    localparam logic [CodeW-1:0] CODE_SAME  = 4'd10;
    localparam logic [CodeW-1:0] CODE_ACK   = 4'd11;
    localparam logic [CodeW-1:0] CODE_REQ   = 4'd12;
    localparam logic [CodeW-1:0] CODE_STOP  = 4'd15;
    localparam logic [CodeW-1:0] CODE_NONE  = 4'd0;

    localparam logic [PhaseW-1:0] PH_IDLE    = 2'd0;
    localparam logic [PhaseW-1:0] PH_SESSION = 2'd1;
    localparam logic [PhaseW-1:0] PH_FRAME   = 2'd2;

    localparam int InDataW  = 8;
    localparam int OutDataW = 16;
    localparam int OutUserW = 3;
    localparam int AddrW    = 3;
    localparam int ApbDataW = 32;

    localparam logic [AddrW-1:0] ADDR_SIDE_SELECT = 3'd0;

    // m_tuser bit positions
    localparam int USER_BYTE_VALID   = 0;
    localparam int USER_PARITY_FAIL  = 1;
    localparam int USER_SESSION_DONE = 2;

    typedef logic [PacketW-1:0] t_packet;

endpackage

### hw/rtl/nibble_link_framed_receiver.sv
// Nibble link framed receiver: handshake state, packet collection and parity check.
// Depends on nlfr_pkg.
//
//  channel   dir  handshake                      carries
//  s_*       in   s_tvalid/s_tready              port_in, one line sample per beat
//  m_*       out  m_tvalid/m_tready              port_out, rx_byte, status flags
//  apb       in   psel/penable/pwrite/pready     side_select, written at byte addresses 0-3
//
// One sample per cycle while m_* is not stalled; a taken beat's result is registered and valid in the next cycle.
// The result register is the only stage: s_tready is high when it is empty or
// being drained, so a stall on m_* stops intake only while a result is held.
// Reset (synchronous, active low) returns to idle, drive code 0, side_select 1.
module nibble_link_framed_receiver (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [nlfr_pkg::InDataW-1:0]  s_tdata,   // [7:0] port_in
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [nlfr_pkg::OutDataW-1:0] m_tdata,   // [7:0] port_out, [15:8] rx_byte
    output logic [nlfr_pkg::OutUserW-1:0] m_tuser,   // [0] byte_valid, [1] parity_fail,
                                                     // [2] session_done
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nlfr_pkg::AddrW-1:0]    paddr,
    input  logic [nlfr_pkg::ApbDataW-1:0] pwdata,
    output logic [nlfr_pkg::ApbDataW-1:0] prdata,
    output logic                          pready
);
    import nlfr_pkg::*;

    logic                r_side;
    logic [PhaseW-1:0]   r_phase,    n_phase;
    logic [CodeW-1:0]    r_prev,     n_prev;
    logic [HeldW-1:0]    r_held,     n_held;
    logic [CodeW-1:0]    r_drive,    n_drive;
    t_packet             r_store [3];
    logic                n_store_we;
    logic [1:0]          n_store_idx;

    logic                r_m_valid;
    logic [OutDataW-1:0] r_m_data,   n_m_data;
    logic [OutUserW-1:0] r_m_user,   n_m_user;

    logic                accept;
    logic [CodeW-1:0]    code;
    t_packet             pkt;
    logic                par_ok;
    logic [7:0]          byte_val;
    logic                valid, fail, done;

    assign pready   = 1'b1;
    assign prdata   = {{(ApbDataW-1){1'b0}}, r_side};
    assign s_tready = !r_m_valid || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;
    assign m_tuser  = r_m_user;

    assign code = r_side ? s_tdata[3:0] : s_tdata[7:4];
    assign pkt  = code[PacketW-1:0];
    // third packet is still on the line, not yet in the store
    assign par_ok   = pkt[2] == (^r_store[0] ^ ^r_store[1] ^ ^pkt[1:0]);
    assign byte_val = {pkt[1:0], r_store[1], r_store[0]};

    always_comb begin
        n_phase     = r_phase;
        n_prev      = r_prev;
        n_held      = r_held;
        n_drive     = r_drive;
        n_store_we  = 1'b0;
        n_store_idx = (r_held == 2'd3) ? 2'd0 : r_held;
        valid       = 1'b0;
        fail        = 1'b0;
        done        = 1'b0;
        unique case (r_phase)
            PH_SESSION: begin
                if (code == CODE_STOP) begin
                    n_drive = CODE_NONE;
                    done    = 1'b1;
                    n_phase = PH_IDLE;
                end else if (code == CODE_START) begin
                    n_prev  = CODE_START;
                    n_drive = CODE_NONE;
                    n_held  = '0;
                    n_phase = PH_FRAME;
                end
            end
            PH_FRAME: begin
                if (code != CODE_START && code != r_prev) begin
                    n_prev = code;
                    if (code != CODE_SAME) begin
                        n_store_we = 1'b1;
                        n_held     = r_held + 2'd1;
                        if (n_held == 2'd3) begin
                            if (par_ok) begin
                                n_drive = CODE_ACK;
                                valid   = 1'b1;
                            end else begin
                                n_drive = CODE_DEN;
                                fail    = 1'b1;
                            end
                            n_held  = '0;
                            n_phase = PH_SESSION;
                        end
                    end
                end
            end
            default: begin
                // idle, and the unused phase code behaves the same
                n_phase = PH_IDLE;
                if (code == CODE_REQ) begin
                    n_drive = CODE_ACK;
                    n_phase = PH_SESSION;
                end
            end
        endcase

        n_m_data[7:0]  = r_side ? {n_drive, 4'b0000} : {4'b0000, n_drive};
        n_m_data[15:8] = valid ? byte_val : 8'd0;
        n_m_user[USER_BYTE_VALID]   = valid;
        n_m_user[USER_PARITY_FAIL]  = fail;
        n_m_user[USER_SESSION_DONE] = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side    <= 1'b1;
            r_phase   <= PH_IDLE;
            r_prev    <= CODE_NONE;
            r_held    <= '0;
            r_drive   <= CODE_NONE;
            r_m_valid <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == ADDR_SIDE_SELECT[2]) begin
                r_side <= pwdata[0];
            end
            if (accept) begin
                r_phase   <= n_phase;
                r_prev    <= n_prev;
                r_held    <= n_held;
                r_drive   <= n_drive;
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_m_data <= n_m_data;
            r_m_user <= n_m_user;
            if (n_store_we) begin
                r_store[n_store_idx] <= pkt;
            end
        end
    end

endmodule

### hw/rtl/nlfr_checker.sv
// Port-level checks for the nibble link framed receiver, bound to the top level.
// Depends on nlfr_pkg.
module nlfr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [nlfr_pkg::OutDataW-1:0] m_tdata,
    input logic [nlfr_pkg::OutUserW-1:0] m_tuser
);
    import nlfr_pkg::*;

    // a held result beat keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> $onehot0(m_tuser))
        else $error("more than one status flag set");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser[USER_BYTE_VALID] |-> m_tdata[15:8] == 8'd0)
        else $error("rx_byte nonzero without a delivered byte");

    a_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[USER_BYTE_VALID]
        |-> m_tdata[7:0] == {CODE_ACK, 4'b0000} || m_tdata[7:0] == {4'b0000, CODE_ACK})
        else $error("delivered byte without ACK driven");

    a_den_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser[USER_PARITY_FAIL] || m_tuser[USER_SESSION_DONE])
        |-> (m_tuser[USER_SESSION_DONE] && m_tdata[7:0] == 8'd0)
         || (m_tuser[USER_PARITY_FAIL] && (m_tdata[7:0] == {CODE_DEN, 4'b0000}
                                        || m_tdata[7:0] == {4'b0000, CODE_DEN})))
        else $error("drive code does not match frame outcome");

endmodule

bind nibble_link_framed_receiver nlfr_checker u_nlfr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
